@@ hw/rtl/lrud_pkg.sv @@
// Shared types and constants for the radial undistortion block.
package lrud_pkg;

  localparam int POINT_W   = 24;
  localparam int DELTA_W   = 25;
  localparam int RADIUS_W  = 24;
  localparam int FOCAL_W   = 25;
  localparam int INDEX_W   = 8;
  localparam int RAY_W     = 16;
  localparam int COUNT_W   = 9;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int MUL_W     = 31;
  localparam int SQRT_W    = 62;
  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = 32;
  localparam int FOC_EXT_W = 54;
  localparam int MAG_W     = 53;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_ENTRIES  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]       radius;
    logic signed [FOCAL_W-1:0] focal;
  } entry_t;

  typedef struct packed {
    entry_t lo;
    entry_t hi;
  } pair_t;

endpackage

@@ hw/rtl/lrud_if.sv @@
// Request and ray channel interfaces.
interface lrud_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [lrud_pkg::POINT_W-1:0]  point_x;
  logic signed [lrud_pkg::POINT_W-1:0]  point_y;
  logic [lrud_pkg::INDEX_W-1:0]         entry_index;
  logic [lrud_pkg::RADIUS_W-1:0]        entry_radius;
  logic signed [lrud_pkg::FOCAL_W-1:0]  entry_focal;

  modport source (output valid, req_type, point_x, point_y, entry_index, entry_radius,
                  entry_focal, input ready);
  modport sink (input valid, req_type, point_x, point_y, entry_index, entry_radius,
                entry_focal, output ready);
endinterface

interface lrud_ray_if;
  logic                               valid;
  logic                               ready;
  logic signed [lrud_pkg::RAY_W-1:0]  ray_x;
  logic signed [lrud_pkg::RAY_W-1:0]  ray_y;
  logic signed [lrud_pkg::RAY_W-1:0]  ray_z;
  logic                               degenerate;

  modport source (output valid, ray_x, ray_y, ray_z, degenerate, input ready);
  modport sink (input valid, ray_x, ray_y, ray_z, degenerate, output ready);
endinterface

@@ hw/rtl/lrud_cell.sv @@
// One table cell of the rotating radius/focal ring.
module lrud_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  lrud_pkg::entry_t wr_data,
  input  lrud_pkg::entry_t nbr,
  output lrud_pkg::entry_t q
);
  import lrud_pkg::*;

  // Load a written entry, else take the neighbour's entry while the ring turns.
  always_ff @(posedge clk) begin
    if (load) begin
      q <= wr_data;
    end else if (shift) begin
      q <= nbr;
    end
  end

endmodule

@@ hw/rtl/lrud_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
module lrud_sqrt #(
  parameter int W = 62
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     operand,
  output logic             done,
  output logic [W/2-1:0]   root
);
  import lrud_pkg::*;

  localparam int H  = W / 2;
  localparam int CW = $clog2(H + 1);

  logic [W-1:0]   val;
  logic [H+1:0]   rem;
  logic [CW-1:0]  cnt;
  logic           running;
  logic [H+3:0]   rem_sh;
  logic [H+3:0]   trial;
  logic           fits;

  assign rem_sh = {rem, val[W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        val     <= operand;
        rem     <= '0;
        root    <= '0;
        cnt     <= CW'(H);
        running <= 1'b1;
      end else if (running) begin
        rem  <= fits ? (H+2)'(rem_sh - trial) : (H+2)'(rem_sh);
        root <= {root[H-2:0], fits};
        val  <= val << 2;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/lrud_div.sv @@
// Iterative unsigned restoring divider, one quotient bit per cycle.
module lrud_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  import lrud_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             running;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign rem_sh = {rem, num_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_q   <= num;
        den_q   <= den;
        rem     <= '0;
        quo     <= '0;
        cnt     <= CW'(NUM_W);
        running <= 1'b1;
      end else if (running) begin
        rem   <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo   <= {quo[NUM_W-2:0], fits};
        num_q <= num_q << 1;
        cnt   <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/lut_radial_undistort_top.sv @@
// Top level of the piecewise linear radial undistortion block.
//
// Usage: words arrive on the req channel (valid/ready). A word with req_type 0
// writes one (radius, focal) entry into the table and gives no result; a word
// with req_type 1 is an image point and gives exactly one ray word on the ray
// channel. The user sets center_x, center_y and entries_in_use over the APB port
// only while the block is idle, which the block does not enforce; pready is always high.
// The table lives in a ring of TABLE_DEPTH cells. A point takes a square root
// for its radius, one full turn of the ring to find its bracket, a divide for
// the focal length, right shifts to normalise, a second square root and three
// more divides for the components; a degenerate result skips the later steps.
// One point is in work at a time; the square root, divider and ring are shared.
// The ray word sits in an output register, so a new word is accepted while it
// waits; a finished point holds in its last step until that register frees.
// Reset returns the registers to center 0 and two entries in use and empties
// the output register; the table keeps no reset value and must be written.
module lut_radial_undistort_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  lrud_req_if.sink                       req,
  lrud_ray_if.source                     ray,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrud_pkg::PADDR_W-1:0]   paddr,
  input  logic [lrud_pkg::PDATA_W-1:0]   pwdata,
  output logic [lrud_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import lrud_pkg::*;

  localparam int DEPTH_W = $clog2(TABLE_DEPTH);
  localparam int EW      = (DEPTH_W + 1 > COUNT_W) ? DEPTH_W + 1 : COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_DX, S_MUL_DY, S_RSUM, S_RSQRT, S_SCAN, S_PICK, S_MUL_F,
    S_DIV_F, S_WAIT_F, S_ABS, S_NORM, S_SS_X, S_SS_Y, S_SS_Z, S_SS_SUM,
    S_NSQRT, S_COMP, S_WAIT_C, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    COMP_X, COMP_Y, COMP_Z
  } comp_t;

  state_t state;
  comp_t  comp;

  // Configuration registers.
  logic signed [POINT_W-1:0] center_x;
  logic signed [POINT_W-1:0] center_y;
  logic [COUNT_W-1:0]        entries_in_use;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_CENTER_X: prdata = {{(PDATA_W-POINT_W){center_x[POINT_W-1]}}, center_x};
      REG_CENTER_Y: prdata = {{(PDATA_W-POINT_W){center_y[POINT_W-1]}}, center_y};
      REG_ENTRIES:  prdata = {{(PDATA_W-COUNT_W){1'b0}}, entries_in_use};
      default:      prdata = '0;
    endcase
  end

  // Effective entry count, clamped to the table.
  logic [EW-1:0]      n_ext;
  logic [EW-1:0]      n_eff;
  logic [DEPTH_W-1:0] last_idx;

  assign n_ext = EW'(entries_in_use);
  always_comb begin
    if (n_ext < EW'(2)) begin
      n_eff = EW'(2);
    end else if (n_ext > EW'(TABLE_DEPTH)) begin
      n_eff = EW'(TABLE_DEPTH);
    end else begin
      n_eff = n_ext;
    end
  end
  assign last_idx = DEPTH_W'(n_eff - EW'(2));

  // Table ring: cell 0 and cell 1 are the head pair seen by the bracket search.
  logic          accept;
  logic          wr_en;
  logic [EW-1:0] idx_ext;
  entry_t        wr_entry;
  logic          ring_shift;
  entry_t        cell_q [TABLE_DEPTH];

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid & req.ready;
  assign idx_ext    = EW'(req.entry_index);
  assign wr_en      = accept & ~req.req_type & (idx_ext < EW'(TABLE_DEPTH));
  assign wr_entry   = '{radius: req.entry_radius, focal: req.entry_focal};
  assign ring_shift = (state == S_SCAN);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lrud_cell u_cell (
      .clk     (clk),
      .shift   (ring_shift),
      .load    (wr_en && (idx_ext == EW'(i))),
      .wr_data (wr_entry),
      .nbr     (cell_q[(i + 1) % TABLE_DEPTH]),
      .q       (cell_q[i])
    );
  end

  // Point datapath registers.
  logic signed [DELTA_W-1:0]   dx;
  logic signed [DELTA_W-1:0]   dy;
  logic [DELTA_W-1:0]          r;
  logic signed [2*MUL_W-1:0]   prod;
  logic [SQRT_W-1:0]           acc;
  logic [DEPTH_W-1:0]          scan_cnt;
  logic                        found;
  pair_t                       pair_first;
  pair_t                       pair_last;
  pair_t                       pair_hit;
  pair_t                       sel;
  logic                        f_neg;
  logic signed [FOC_EXT_W-1:0] f;
  logic [MAG_W-1:0]            ax;
  logic [MAG_W-1:0]            ay;
  logic [MAG_W-1:0]            af;
  logic [SQRT_W/2-1:0]         norm;
  logic signed [RAY_W-1:0]     res_x;
  logic signed [RAY_W-1:0]     res_y;
  logic signed [RAY_W-1:0]     res_z;
  logic                        res_deg;

  // Output register.
  logic                        out_valid;
  logic signed [RAY_W-1:0]     out_x;
  logic signed [RAY_W-1:0]     out_y;
  logic signed [RAY_W-1:0]     out_z;
  logic                        out_deg;

  assign ray.valid      = out_valid;
  assign ray.ray_x      = out_x;
  assign ray.ray_y      = out_y;
  assign ray.ray_z      = out_z;
  assign ray.degenerate = out_deg;

  // Head pair and bracket arithmetic.
  entry_t                cur;
  entry_t                nxt;
  logic                  hit;
  logic signed [25:0]    df;
  logic signed [25:0]    dr;
  logic signed [25:0]    rr;
  logic [DIV_DEN_W-1:0]  dr_abs;
  logic [DIV_NUM_W-1:0]  prod_abs;
  logic [2*MUL_W-1:0]    prod_u;

  assign cur      = cell_q[0];
  assign nxt      = cell_q[1 % TABLE_DEPTH];
  assign hit      = ({1'b0, cur.radius} < r) && (r <= {1'b0, nxt.radius});
  assign df       = 26'(sel.hi.focal) - 26'(sel.lo.focal);
  assign dr       = {2'b00, sel.hi.radius} - {2'b00, sel.lo.radius};
  assign rr       = {1'b0, r} - {2'b00, sel.lo.radius};
  assign dr_abs   = DIV_DEN_W'(dr[25] ? -dr : dr);
  assign prod_abs = DIV_NUM_W'(prod[2*MUL_W-1] ? -prod : prod);
  assign prod_u   = prod;

  // Shared multiplier; register its product before any use.
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;

  always_comb begin
    case (state)
      S_MUL_DX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      S_MUL_DY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      S_MUL_F: begin
        mul_a = MUL_W'(df);
        mul_b = MUL_W'(rr);
      end
      S_SS_X: begin
        mul_a = {1'b0, ax[29:0]};
        mul_b = {1'b0, ax[29:0]};
      end
      S_SS_Y: begin
        mul_a = {1'b0, ay[29:0]};
        mul_b = {1'b0, ay[29:0]};
      end
      S_SS_Z: begin
        mul_a = {1'b0, af[29:0]};
        mul_b = {1'b0, af[29:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Square root and divider, shared between the radius/norm and focal/component steps.
  logic                 sq_start;
  logic                 sq_done;
  logic [SQRT_W/2-1:0]  sq_root;
  logic                 dv_start;
  logic                 dv_done;
  logic [DIV_NUM_W-1:0] dv_num;
  logic [DIV_DEN_W-1:0] dv_den;
  logic [DIV_NUM_W-1:0] dv_quo;
  logic [29:0]          comp_mag;
  logic                 comp_neg;
  logic [RAY_W-1:0]     comp_sat;
  logic signed [RAY_W-1:0] comp_val;

  assign sq_start = (state == S_RSUM) || (state == S_SS_SUM);

  lrud_sqrt #(.W(SQRT_W)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (acc + prod_u),
    .done    (sq_done),
    .root    (sq_root)
  );

  always_comb begin
    case (comp)
      COMP_X: begin
        comp_mag = ax[29:0];
        comp_neg = dx[DELTA_W-1];
      end
      COMP_Y: begin
        comp_mag = ay[29:0];
        comp_neg = dy[DELTA_W-1];
      end
      COMP_Z: begin
        comp_mag = af[29:0];
        comp_neg = f[FOC_EXT_W-1];
      end
      default: begin
        comp_mag = '0;
        comp_neg = 1'b0;
      end
    endcase
  end

  assign dv_start = (state == S_DIV_F) || (state == S_COMP);

  always_comb begin
    if (state == S_DIV_F) begin
      dv_num = prod_abs + DIV_NUM_W'(dr_abs >> 1);
      dv_den = dr_abs;
    end else begin
      dv_num = DIV_NUM_W'({comp_mag, 15'b0}) + DIV_NUM_W'(norm >> 1);
      dv_den = DIV_DEN_W'(norm);
    end
  end

  lrud_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // Saturate the component to 32767 and restore its sign.
  assign comp_sat = (dv_quo > DIV_NUM_W'(32767)) ? RAY_W'(32767) : dv_quo[RAY_W-1:0];
  assign comp_val = comp_neg ? -comp_sat : comp_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      comp           <= COMP_X;
      out_valid      <= 1'b0;
      center_x       <= '0;
      center_y       <= '0;
      entries_in_use <= COUNT_W'(2);
    end else begin
      if (cfg_wr) begin
        case (paddr[PADDR_W-1:2])
          REG_CENTER_X: center_x       <= pwdata[POINT_W-1:0];
          REG_CENTER_Y: center_y       <= pwdata[POINT_W-1:0];
          REG_ENTRIES:  entries_in_use <= pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end

      // Drop the word once taken; the final step refills the register itself.
      if (ray.valid && ray.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      prod <= mul_a * mul_b;

      case (state)
        S_IDLE: begin
          if (accept && req.req_type) begin
            dx    <= DELTA_W'(req.point_x) - DELTA_W'(center_x);
            dy    <= DELTA_W'(req.point_y) - DELTA_W'(center_y);
            state <= S_MUL_DX;
          end
        end
        S_MUL_DX: state <= S_MUL_DY;
        S_MUL_DY: begin
          acc   <= prod_u;
          state <= S_RSUM;
        end
        S_RSUM: state <= S_RSQRT;
        S_RSQRT: begin
          if (sq_done) begin
            r        <= sq_root[DELTA_W-1:0];
            scan_cnt <= '0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // The ring advances one entry per cycle; capture pairs as they pass the head.
          if (scan_cnt == '0) begin
            pair_first <= '{lo: cur, hi: nxt};
          end
          if (scan_cnt == last_idx) begin
            pair_last <= '{lo: cur, hi: nxt};
          end
          if (!found && (scan_cnt <= last_idx) && hit) begin
            pair_hit <= '{lo: cur, hi: nxt};
            found    <= 1'b1;
          end
          if (scan_cnt == DEPTH_W'(TABLE_DEPTH - 1)) begin
            state <= S_PICK;
          end else begin
            scan_cnt <= scan_cnt + DEPTH_W'(1);
          end
        end
        S_PICK: begin
          if (r < {1'b0, pair_first.lo.radius}) begin
            sel <= pair_first;
          end else if (r > {1'b0, pair_last.hi.radius}) begin
            sel <= pair_last;
          end else if (found) begin
            sel <= pair_hit;
          end else begin
            sel <= pair_first;
          end
          state <= S_MUL_F;
        end
        S_MUL_F: begin
          if (sel.lo.radius == sel.hi.radius) begin
            res_x   <= '0;
            res_y   <= '0;
            res_z   <= '0;
            res_deg <= 1'b1;
            state   <= S_FINISH;
          end else begin
            state <= S_DIV_F;
          end
        end
        S_DIV_F: begin
          f_neg <= prod[2*MUL_W-1] ^ dr[25];
          state <= S_WAIT_F;
        end
        S_WAIT_F: begin
          if (dv_done) begin
            f <= FOC_EXT_W'(sel.lo.focal) +
                 (f_neg ? -FOC_EXT_W'(dv_quo) : FOC_EXT_W'(dv_quo));
            state <= S_ABS;
          end
        end
        S_ABS: begin
          ax <= MAG_W'(dx[DELTA_W-1] ? -dx : dx);
          ay <= MAG_W'(dy[DELTA_W-1] ? -dy : dy);
          af <= MAG_W'(f[FOC_EXT_W-1] ? -f : f);
          if (dx == '0 && dy == '0 && f == '0) begin
            res_x   <= '0;
            res_y   <= '0;
            res_z   <= '0;
            res_deg <= 1'b1;
            state   <= S_FINISH;
          end else begin
            res_deg <= 1'b0;
            state   <= S_NORM;
          end
        end
        S_NORM: begin
          // Halve all three together until each is below 2^30.
          if ((ax | ay | af) >> 30 != '0) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
            af <= af >> 1;
          end else begin
            state <= S_SS_X;
          end
        end
        S_SS_X: state <= S_SS_Y;
        S_SS_Y: begin
          acc   <= prod_u;
          state <= S_SS_Z;
        end
        S_SS_Z: begin
          acc   <= acc + prod_u;
          state <= S_SS_SUM;
        end
        S_SS_SUM: state <= S_NSQRT;
        S_NSQRT: begin
          if (sq_done) begin
            norm <= sq_root;
            comp <= COMP_X;
            if (sq_root == '0) begin
              res_x   <= '0;
              res_y   <= '0;
              res_z   <= '0;
              res_deg <= 1'b1;
              state   <= S_FINISH;
            end else begin
              state <= S_COMP;
            end
          end
        end
        S_COMP: state <= S_WAIT_C;
        S_WAIT_C: begin
          if (dv_done) begin
            case (comp)
              COMP_X: begin
                res_x <= comp_val;
                comp  <= COMP_Y;
                state <= S_COMP;
              end
              COMP_Y: begin
                res_y <= comp_val;
                comp  <= COMP_Z;
                state <= S_COMP;
              end
              default: begin
                res_z <= comp_val;
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_FINISH: begin
          // Hold until the output register is free, then hand the word over.
          if (!out_valid || ray.ready) begin
            out_x     <= res_x;
            out_y     <= res_y;
            out_z     <= res_z;
            out_deg   <= res_deg;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sim/lrud_checker.sv @@
// Ray predictor and scoreboard for the radial undistortion block.
module lrud_checker (
  input  logic                         clk,
  input  logic                         rst,
  lrud_req_if                          req,
  lrud_ray_if                          ray,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [lrud_pkg::PADDR_W-1:0] paddr,
  input  logic [lrud_pkg::PDATA_W-1:0] pwdata,
  output int                           fail_count,
  output int                           pending
);
  import lrud_pkg::*;

  localparam int DEPTH = 256;

  typedef struct packed {
    logic signed [RAY_W-1:0] x;
    logic signed [RAY_W-1:0] y;
    logic signed [RAY_W-1:0] z;
    logic                    degen;
  } ray_word_t;

  logic [RADIUS_W-1:0]       radius_mem [DEPTH];
  logic signed [FOCAL_W-1:0] focal_mem  [DEPTH];
  longint                    cen_x, cen_y;
  logic [COUNT_W-1:0]        n_used;
  ray_word_t                 rays_due [$];

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint div_near(longint num, longint den);
    longint unsigned an, ad, q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an + ad / 2) / ad;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [RAY_W-1:0] unit_comp(longint v, longint unsigned mag,
                                                         longint unsigned nrm);
    longint unsigned q;
    q = (mag * 32768 + nrm / 2) / nrm;
    if (q > 32767) q = 32767;
    return (v < 0) ? -RAY_W'(q) : RAY_W'(q);
  endfunction

  function automatic ray_word_t predict_ray(logic signed [POINT_W-1:0] px,
                                            logic signed [POINT_W-1:0] py);
    longint dx, dy, r, r1, r2, f1, f2, f;
    longint unsigned ax, ay, af, mx, nrm;
    int nn, k1, s;
    ray_word_t w;
    w = '{x: 0, y: 0, z: 0, degen: 1'b1};
    dx = longint'(px) - cen_x;
    dy = longint'(py) - cen_y;
    r = longint'(isqrt(longint'(dx * dx) + longint'(dy * dy)));
    nn = int'(n_used);
    if (nn < 2) nn = 2;
    if (nn > DEPTH) nn = DEPTH;
    k1 = 0;
    if (r < longint'(radius_mem[0])) begin
      k1 = 0;
    end else if (r > longint'(radius_mem[nn-1])) begin
      k1 = nn - 2;
    end else begin
      for (int k = 0; k + 1 < nn; k++) begin
        if (longint'(radius_mem[k]) < r && r <= longint'(radius_mem[k+1])) begin
          k1 = k;
          break;
        end
      end
    end
    r1 = longint'(radius_mem[k1]);
    r2 = longint'(radius_mem[k1+1]);
    f1 = longint'(focal_mem[k1]);
    f2 = longint'(focal_mem[k1+1]);
    if (r2 == r1) return w;
    f = f1 + div_near((f2 - f1) * (r - r1), r2 - r1);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    af = (f < 0) ? -f : f;
    if (ax == 0 && ay == 0 && af == 0) return w;
    mx = ax;
    if (ay > mx) mx = ay;
    if (af > mx) mx = af;
    s = 0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    ax = ax >> s;
    ay = ay >> s;
    af = af >> s;
    nrm = isqrt(ax * ax + ay * ay + af * af);
    if (nrm == 0) return w;
    w.x = unit_comp(dx, ax, nrm);
    w.y = unit_comp(dy, ay, nrm);
    w.z = unit_comp(f, af, nrm);
    w.degen = 1'b0;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    ray_word_t w;
    reg_index_t ri;
    if (rst) begin
      cen_x <= 0;
      cen_y <= 0;
      n_used <= COUNT_W'(2);
    end else begin
      if (psel && penable && pwrite && pready) begin
        ri = reg_index_t'(paddr[3:2]);
        case (ri)
          REG_CENTER_X: cen_x <= longint'($signed(pwdata[POINT_W-1:0]));
          REG_CENTER_Y: cen_y <= longint'($signed(pwdata[POINT_W-1:0]));
          REG_ENTRIES:  n_used <= pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.req_type == 1'b0) begin
          radius_mem[req.entry_index] <= req.entry_radius;
          focal_mem[req.entry_index] <= req.entry_focal;
        end else begin
          rays_due.push_back(predict_ray(req.point_x, req.point_y));
        end
      end
      if (ray.valid && ray.ready) begin
        if (rays_due.size() == 0) begin
          report_mismatch("unexpected ray word, degenerate", ray.degenerate, 0);
        end else begin
          w = rays_due.pop_front();
          if (ray.ray_x !== w.x) report_mismatch("ray_x", ray.ray_x, w.x);
          if (ray.ray_y !== w.y) report_mismatch("ray_y", ray.ray_y, w.y);
          if (ray.ray_z !== w.z) report_mismatch("ray_z", ray.ray_z, w.z);
          if (ray.degenerate !== w.degen)
            report_mismatch("degenerate", ray.degenerate, w.degen);
        end
      end
      pending = rays_due.size();
    end
  end
endmodule

@@ sim/tb_lut_radial_undistort_top.sv @@
// Stimulus and verdict for the radial undistortion block.
module tb_lut_radial_undistort_top;
  import lrud_pkg::*;

  logic                clk;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int                  fail_count, pending;

  // idle percentages for each side; the main process picks them per phase
  int                  send_idle, recv_idle;
  // each bump asks the receiver for one long hold-off
  int                  hold_requests;
  int                  cur_cx, cur_cy;
  logic [RADIUS_W-1:0] shadow_radius [256];

  lrud_req_if req_ch ();
  lrud_ray_if ray_ch ();

  lut_radial_undistort_top #(.TABLE_DEPTH(256)) dut (
    .clk(clk), .rst(rst), .req(req_ch), .ray(ray_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lrud_checker chk (
    .clk(clk), .rst(rst), .req(req_ch), .ray(ray_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: random ready at each falling edge; on request, drop ready for a
  // long stretch so the output register fills and the block stalls its input.
  initial ray_ch.ready = 1'b0;
  always @(negedge clk) begin
    static int hold_left = 0;
    static int holds_seen = 0;
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      ray_ch.ready <= 1'b0;
    end else begin
      ray_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Generous limit on the length of the whole run.
  initial begin
    #30000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one word and hold it until the block takes it; leave valid high,
  // the next call or the caller decides whether it drops.
  task automatic send_word(logic t, logic [POINT_W-1:0] px, logic [POINT_W-1:0] py,
                           logic [INDEX_W-1:0] idx, logic [RADIUS_W-1:0] rad,
                           logic [FOCAL_W-1:0] foc);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = t;
    req_ch.point_x = px;
    req_ch.point_y = py;
    req_ch.entry_index = idx;
    req_ch.entry_radius = rad;
    req_ch.entry_focal = foc;
    do @(posedge clk); while (!req_ch.ready);
    if (t == 1'b0) shadow_radius[idx] = rad;
    @(negedge clk);
  endtask

  task automatic send_point(int px, int py);
    send_word(1'b1, POINT_W'(px), POINT_W'(py), INDEX_W'($urandom), RADIUS_W'($urandom),
              FOCAL_W'($urandom));
  endtask

  task automatic send_entry(int idx, int rad, int foc);
    send_word(1'b0, POINT_W'($urandom), POINT_W'($urandom), INDEX_W'(idx),
              RADIUS_W'(rad), FOCAL_W'(foc));
  endtask

  // Drop valid and wait for every ray word, then let the block settle.
  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  // APB write: setup phase, then access phase.
  task automatic apb_write(reg_index_t ri, logic [PDATA_W-1:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = PADDR_W'(4 * int'(ri));
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(int cx, int cy, int n);
    drain();
    apb_write(REG_CENTER_X, PDATA_W'(cx));
    apb_write(REG_CENTER_Y, PDATA_W'(cy));
    apb_write(REG_ENTRIES, PDATA_W'(n));
    cur_cx = cx;
    cur_cy = cy;
  endtask

  // One random word: half are points near the centre, mostly inside the table span,
  // some at an exact table radius, some anywhere; the rest rewrite entries.
  task automatic random_word();
    int pick, k;
    pick = $urandom_range(99);
    k = $urandom_range(255);
    if (pick < 50) begin
      send_point(cur_cx + $urandom_range(2400000) - 1200000,
                 cur_cy + $urandom_range(2400000) - 1200000);
    end else if (pick < 65) begin
      send_point(cur_cx + int'(shadow_radius[k]), cur_cy);
    end else if (pick < 85) begin
      send_point(int'($urandom), int'($urandom));
    end else if (pick < 95) begin
      send_entry(k, shadow_radius[k], int'($urandom));
    end else begin
      send_entry(k, int'($urandom), int'($urandom));
    end
  endtask

  initial begin
    int cfg_x [6], cfg_y [6], cfg_n [6];
    hold_requests = 0;
    send_idle = 0;
    recv_idle = 0;
    cur_cx = 0;
    cur_cy = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = 1'b0;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    req_ch.entry_index = '0;
    req_ch.entry_radius = '0;
    req_ch.entry_focal = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole table, sorted, so no point ever reads an unwritten slot.
    for (int k = 0; k < 256; k++)
      send_entry(k, k * 4096 + $urandom_range(4000), 153600 - k * 100 +
                 $urandom_range(2000));

    // Directed: reset setting of two entries, then the full table.
    send_point(0, 0);
    send_point(8388607, 8388607);
    set_config(0, 0, 256);
    send_point(0, 0);
    send_point(8388607, 8388607);
    send_point(-8388608, -8388608);
    send_point(8388607, -8388608);
    send_point(-8388608, 8388607);
    send_point(int'(shadow_radius[100]), 0);
    // zero vector: point at the centre with zero focal in slot 0
    send_entry(0, 0, 0);
    send_point(0, 0);
    // equal bracket radii at the bottom of the table
    send_entry(1, 0, 5000);
    send_point(0, 0);
    send_entry(1, 4096, 153500);
    // focal and radius extremes at the top, in the middle and at the bottom
    send_entry(255, 16777215, 16777215);
    send_point(8388607, 8388607);
    send_entry(200, shadow_radius[200], -16777216);
    send_point(int'(shadow_radius[200]) - 10, 0);
    send_point(0, int'(shadow_radius[200]) + 10);
    send_entry(0, 16777215, -16777216);
    send_point(100, -100);
    send_entry(0, 0, 153600);

    // Phases: extremes of the centre, entry counts clamped from both sides.
    cfg_x = '{8388607, -8388608, 0, 123456, -654321, 0};
    cfg_y = '{-8388608, 8388607, 0, -98765, 300000, 0};
    cfg_n = '{2, 511, 0, 1, 257, 256};
    for (int p = 0; p < 6; p++) begin
      set_config(cfg_x[p], cfg_y[p], cfg_n[p]);
      case (p / 2)
        0: begin send_idle = 18; recv_idle = 75; end
        1: begin send_idle = 75; recv_idle = 18; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int i = 0; i < 20; i++) begin
        // hold the receiver off while the sender keeps offering words
        if (p == 4 && i == 5) hold_requests++;
        // pause the sender until every ray word is back
        if (p == 5 && i == 10) begin
          req_ch.valid = 1'b0;
          while (pending != 0) @(negedge clk);
        end
        random_word();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/lrud_pkg.sv
hw/rtl/lrud_if.sv
hw/rtl/lrud_cell.sv
hw/rtl/lrud_sqrt.sv
hw/rtl/lrud_div.sv
hw/rtl/lut_radial_undistort_top.sv
sim/lrud_checker.sv
sim/tb_lut_radial_undistort_top.sv
